>>> sv/ipf_pkg.sv
// Shared types, constants and helpers for the integer field formatter.
`timescale 1ns / 1ps

package ipf_pkg;

	localparam int VALUE_BITS_DEF      = 64;
	localparam int MAX_FIELD_WIDTH_DEF = 64;

	// character positions within one field
	localparam int POS_W = 7;

	localparam logic [5:0] PREC_LIMIT = 6'd40;

	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		logic [1:0]  radix;
		logic        upper_case;
		logic        left_justify;
		logic        force_sign;
		logic        zero_pad;
		logic        alternate;
		logic        space_sign;
		logic [6:0]  field_width;
		logic        precision_given;
		logic [5:0]  precision;
	} ipf_req_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} ipf_res_t;

	// commands from the sequencer to the digit unit
	typedef struct packed {
		logic load;
		logic conv;
		logic norm;
		logic pop;
	} ipf_dctl_t;

	typedef struct packed {
		logic conv_done;
		logic norm_done;
	} ipf_dstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_LAYOUT,
		ST_PLAN,
		ST_BOUND,
		ST_EMIT
	} ipf_state_t;

	// "0123456789abcdef" / "0123456789ABCDEF"
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_A_UP : CH_A_LO;
		if (d < 4'd10)
			digit_char = CH_ZERO + {4'b0, d};
		else
			digit_char = base + {4'b0, d} - 8'd10;
	endfunction

endpackage

>>> sv/integer_field_formatter.sv
// Integer field formatter: printf-style conversion of one integer to a stream of characters.
// Steps: load, shift-add-3 conversion for decimal (none for octal/hex), leading-zero strip
// in the digit unit, the layout, plan and bound states, then one character per cycle; the
// result stream is registered and starts in the cycle after emission begins. A new request
// is accepted only in idle, once the previous request has been fully emitted.
// Async active-low reset returns the sequencer to idle with no result pending; results cannot stall.
`timescale 1ns / 1ps

module integer_field_formatter #(
	parameter int VALUE_BITS      = ipf_pkg::VALUE_BITS_DEF,
	parameter int MAX_FIELD_WIDTH = ipf_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ipf_pkg::ipf_req_t request,
	output logic              strobe,
	output ipf_pkg::ipf_res_t result
);
	import ipf_pkg::*;

	localparam int NDIG = (VALUE_BITS + 2) / 3;
	localparam int NDW = $clog2(NDIG + 1);
	localparam logic [POS_W-1:0] WMAX = POS_W'(MAX_FIELD_WIDTH);

	ipf_state_t state_q, state_n;
	ipf_dctl_t  dctl;
	ipf_dstat_t dstat;
	logic [NDW-1:0] ndig_raw;
	logic [3:0]     top_digit;

	ipf_req_t         req_q;
	logic [POS_W-1:0] width_q;
	logic [5:0]       prec_q;
	logic             zero_q;

	logic [POS_W-1:0] ndig_q, zeros_q, pad_q;
	logic [1:0]       pre_q;
	logic             has_sign_q;
	logic [7:0]       sign_q;
	logic [POS_W-1:0] lead_q, esign_q, epre_q, ezero_q, edig_q, total_q, pos_q;

	logic             strobe_q;
	ipf_res_t         result_q;

	logic [VALUE_BITS-1:0] mag_v;
	logic                  accept;

	assign mag_v = request.magnitude[VALUE_BITS-1:0];
	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	ipf_digit_unit #(.VALUE_BITS(VALUE_BITS)) u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.mag       (mag_v),
		.radix     (request.radix),
		.stat      (dstat),
		.ndig      (ndig_raw),
		.top_digit (top_digit)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_n = ST_CONV;
			ST_CONV:   if (dstat.conv_done) state_n = ST_NORM;
			ST_NORM:   if (dstat.norm_done) state_n = ST_LAYOUT;
			ST_LAYOUT: state_n = ST_PLAN;
			ST_PLAN:   state_n = ST_BOUND;
			ST_BOUND:  state_n = ST_EMIT;
			ST_EMIT:   if (pos_q + POS_W'(1) >= total_q) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	logic in_digits;
	assign in_digits = (pos_q >= ezero_q) && (pos_q < edig_q);

	// unit commands
	always_comb begin
		dctl = '0;
		unique case (state_q)
			ST_IDLE:  dctl.load = start;
			ST_CONV:  dctl.conv = 1'b1;
			ST_NORM:  dctl.norm = 1'b1;
			ST_EMIT:  dctl.pop = in_digits;
			default:  dctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// layout arithmetic
	logic [POS_W-1:0] ndig_eff, zeros_l, body, zeros_p, pad_p;
	logic [1:0]       pre_l;
	logic             radix_hex;
	logic [7:0]       ch;

	always_comb begin
		radix_hex = (req_q.radix != RADIX_DEC) && (req_q.radix != RADIX_OCT);
		ndig_eff = (req_q.precision_given && prec_q == 6'd0 && zero_q) ? '0
			: POS_W'(ndig_raw);
		zeros_l = (req_q.precision_given && ndig_eff < POS_W'(prec_q))
			? POS_W'(prec_q) - ndig_eff : '0;
		pre_l = 2'd0;
		if (req_q.alternate) begin
			if (radix_hex && !zero_q)
				pre_l = 2'd2;
			else if (req_q.radix == RADIX_OCT && zeros_l == '0 &&
			         !(zero_q && ndig_eff != '0))
				pre_l = 2'd1;
		end

		body = ndig_q + zeros_q + POS_W'(pre_q) + POS_W'(has_sign_q);
		zeros_p = zeros_q;
		pad_p = '0;
		if (!req_q.precision_given && req_q.zero_pad && !req_q.left_justify &&
		    width_q > body)
			zeros_p = zeros_q + (width_q - body);
		else if (width_q > body)
			pad_p = width_q - body;
	end

	// character at the current position
	always_comb begin
		if (pos_q < lead_q)
			ch = CH_SPACE;
		else if (pos_q < esign_q)
			ch = sign_q;
		else if (pos_q < epre_q)
			ch = (pos_q == esign_q) ? CH_ZERO : (req_q.upper_case ? CH_X_UP : CH_X_LO);
		else if (pos_q < ezero_q)
			ch = CH_ZERO;
		else if (pos_q < edig_q)
			ch = digit_char(top_digit, req_q.upper_case);
		else
			ch = CH_SPACE;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
			width_q <= (request.field_width > WMAX) ? WMAX : request.field_width;
			prec_q <= (request.precision > PREC_LIMIT) ? PREC_LIMIT : request.precision;
			zero_q <= (mag_v == '0);
		end
		if (state_q == ST_LAYOUT) begin
			ndig_q <= ndig_eff;
			zeros_q <= zeros_l;
			pre_q <= pre_l;
			has_sign_q <= req_q.negative || req_q.force_sign || req_q.space_sign;
			sign_q <= req_q.negative ? CH_MINUS : (req_q.force_sign ? CH_PLUS : CH_SPACE);
		end
		if (state_q == ST_PLAN) begin
			zeros_q <= zeros_p;
			pad_q <= pad_p;
		end
		if (state_q == ST_BOUND) begin
			lead_q <= req_q.left_justify ? '0 : pad_q;
			esign_q <= (req_q.left_justify ? '0 : pad_q) + POS_W'(has_sign_q);
			epre_q <= (req_q.left_justify ? '0 : pad_q) + POS_W'(has_sign_q) + POS_W'(pre_q);
			ezero_q <= (req_q.left_justify ? '0 : pad_q) + POS_W'(has_sign_q)
				+ POS_W'(pre_q) + zeros_q;
			edig_q <= (req_q.left_justify ? '0 : pad_q) + POS_W'(has_sign_q)
				+ POS_W'(pre_q) + zeros_q + ndig_q;
			total_q <= pad_q + POS_W'(has_sign_q) + POS_W'(pre_q) + zeros_q + ndig_q;
			pos_q <= '0;
		end
		if (state_q == ST_EMIT) begin
			pos_q <= pos_q + POS_W'(1);
			result_q.character <= ch;
			result_q.last <= (pos_q + POS_W'(1) == total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (state_q == ST_EMIT) && (pos_q < total_q);
	end

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !strobe)
		else $error("result strobe without a request in flight");

	a_stream_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("character stream broke before last");

	a_last_ends_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("character after last");

endmodule

>>> sv/ipf_digit_unit.sv
// Digit register: radix split, shift-add-3 decimal conversion, leading-zero strip, digit pop.
`timescale 1ns / 1ps

module ipf_digit_unit #(
	parameter int VALUE_BITS = ipf_pkg::VALUE_BITS_DEF,
	localparam int NDIG = (VALUE_BITS + 2) / 3,
	localparam int NDW = $clog2(NDIG + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipf_pkg::ipf_dctl_t    ctl,
	input  logic [VALUE_BITS-1:0] mag,
	input  logic [1:0]            radix,
	output ipf_pkg::ipf_dstat_t   stat,
	output logic [NDW-1:0]        ndig,
	output logic [3:0]            top_digit
);
	import ipf_pkg::*;

	localparam int DW = 4 * NDIG;
	localparam int BW = $clog2(VALUE_BITS + 1);

	logic [DW-1:0]         dig_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BW-1:0]         bits_q;
	logic [NDW-1:0]        cnt_q;

	logic [DW-1:0]   adj;
	logic [DW-1:0]   oct_ld;
	logic [DW-1:0]   hex_ld;
	logic [3*NDIG-1:0] ext3;

	always_comb begin
		ext3 = (3 * NDIG)'(mag);
		hex_ld = DW'(mag);
		for (int i = 0; i < NDIG; i++) begin
			oct_ld[4*i +: 4] = {1'b0, ext3[3*i +: 3]};
			adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
				: dig_q[4*i +: 4];
		end
	end

	assign top_digit = dig_q[DW-1 -: 4];
	assign ndig = cnt_q;
	assign stat.conv_done = (bits_q == '0);
	assign stat.norm_done = (top_digit != 4'd0) || (cnt_q == NDW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			bits_q <= (radix == RADIX_DEC) ? BW'(VALUE_BITS) : '0;
			cnt_q <= NDW'(NDIG);
		end else if (ctl.conv && bits_q != '0) begin
			bits_q <= bits_q - BW'(1);
		end else if (ctl.norm && !stat.norm_done) begin
			cnt_q <= cnt_q - NDW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= mag;
			unique case (radix)
				RADIX_DEC: dig_q <= '0;
				RADIX_OCT: dig_q <= oct_ld;
				default:   dig_q <= hex_ld;
			endcase
		end else if (ctl.conv && bits_q != '0) begin
			dig_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end else if ((ctl.norm && !stat.norm_done) || ctl.pop) begin
			dig_q <= {dig_q[DW-5:0], 4'd0};
		end
	end

endmodule
